### src/fcwd_pkg.sv
// Shared types, register indexes and constants of the frequency window detector.
package fcwd_pkg;

  localparam int CHANNELS_DEF = 4;
  localparam int TIME_W       = 32;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 3;

  localparam logic [CFG_W-1:0] SAMPLE_PERIOD_RST = CFG_W'(10);
  localparam logic [CFG_W-1:0] PERIOD_MIN_RST    = CFG_W'(10);
  localparam logic [CFG_W-1:0] PERIOD_MAX_RST    = CFG_W'(100);
  localparam logic [CFG_W-1:0] EDGE_TIMEOUT_RST  = CFG_W'(1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FREQ_MODE     = 3'd0,
    REG_SAMPLE_PERIOD = 3'd1,
    REG_PERIOD_MIN    = 3'd2,
    REG_PERIOD_MAX    = 3'd3,
    REG_EDGE_TIMEOUT  = 3'd4
  } cfg_idx_t;

  // Timing settings shared by the lanes and the sampler.
  typedef struct packed {
    logic [CFG_W-1:0] sample_period;
    logic [CFG_W-1:0] period_min;
    logic [CFG_W-1:0] period_max;
    logic [CFG_W-1:0] edge_timeout;
  } cfg_t;

endpackage

### src/four_channel_frequency_window_detector.sv
// Top level of the four-channel frequency window detector.
//
// Each input transfer is one millisecond tick carrying an edge mask and the pin levels
// of every channel; each tick yields exactly one result transfer with the detect flags
// and the sampled digital levels. One tick is accepted per clock cycle while the skid
// entry is free: the tick counter increment, the per-channel 32-bit period subtract
// and window compares in the lanes, and the sample test are all combinational, and the
// result lands in a two-entry output buffer, so the block keeps taking ticks while one
// result waits. Input ready falls only when both buffer entries are full. Configuration
// writes take effect at the next clock edge and belong to idle periods; indexes past the
// last register are ignored. All time differences wrap modulo 2^32.
module four_channel_frequency_window_detector #(
  parameter int CHANNELS = fcwd_pkg::CHANNELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration write port
  input  logic                           cfg_we,
  input  logic [fcwd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fcwd_pkg::CFG_W-1:0]     cfg_wdata,
  // Tick input
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [CHANNELS-1:0]            in_edge_mask,
  input  logic [CHANNELS-1:0]            in_pin_levels,
  // Results
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [CHANNELS-1:0]            out_freq_detected,
  output logic [CHANNELS-1:0]            out_digital_inputs
);

  // Configuration registers
  logic [CHANNELS-1:0]         freq_mode_r;
  fcwd_pkg::cfg_t              cfg_r;

  logic [fcwd_pkg::TIME_W-1:0] tick_r, tick_nxt;
  logic                        fire;
  logic [CHANNELS-1:0]         flags_nxt;
  logic [CHANNELS-1:0]         levels_nxt;

  // Output buffer: head register plus skid entry
  logic                        out_valid_r, out_valid_nxt;
  logic                        skid_valid_r, skid_valid_nxt;
  logic [CHANNELS-1:0]         out_freq_r, out_freq_nxt;
  logic [CHANNELS-1:0]         out_dig_r, out_dig_nxt;
  logic [CHANNELS-1:0]         skid_freq_r, skid_freq_nxt;
  logic [CHANNELS-1:0]         skid_dig_r, skid_dig_nxt;
  logic                        pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_mode_r         <= '0;
      cfg_r.sample_period <= fcwd_pkg::SAMPLE_PERIOD_RST;
      cfg_r.period_min    <= fcwd_pkg::PERIOD_MIN_RST;
      cfg_r.period_max    <= fcwd_pkg::PERIOD_MAX_RST;
      cfg_r.edge_timeout  <= fcwd_pkg::EDGE_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fcwd_pkg::REG_FREQ_MODE:     freq_mode_r         <= cfg_wdata[CHANNELS-1:0];
        fcwd_pkg::REG_SAMPLE_PERIOD: cfg_r.sample_period <= cfg_wdata;
        fcwd_pkg::REG_PERIOD_MIN:    cfg_r.period_min    <= cfg_wdata;
        fcwd_pkg::REG_PERIOD_MAX:    cfg_r.period_max    <= cfg_wdata;
        fcwd_pkg::REG_EDGE_TIMEOUT:  cfg_r.edge_timeout  <= cfg_wdata;
        default: ;  // unmapped index, drop the write
      endcase
    end
  end

  // Accept a tick whenever the skid entry is free.
  assign in_ready = !skid_valid_r;
  assign fire     = in_valid && in_ready;
  assign tick_nxt = tick_r + 1'b1;  // "now" of the tick being accepted

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
    end else if (fire) begin
      tick_r <= tick_nxt;
    end
  end

  // One lane per channel; the flags merge into the result vector.
  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    fcwd_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .fire      (fire),
      .edge_in   (in_edge_mask[g]),
      .freq_mode (freq_mode_r[g]),
      .now       (tick_nxt),
      .cfg       (cfg_r),
      .flag_nxt  (flags_nxt[g])
    );
  end

  fcwd_sampler #(
    .CHANNELS (CHANNELS)
  ) u_sampler (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .now        (tick_nxt),
    .pins       (in_pin_levels),
    .freq_mode  (freq_mode_r),
    .cfg        (cfg_r),
    .levels_nxt (levels_nxt)
  );

  // Advance the buffer: pop first, then push the new result into the first free entry.
  assign pop = out_valid_r && out_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_freq_nxt   = out_freq_r;
    out_dig_nxt    = out_dig_r;
    skid_freq_nxt  = skid_freq_r;
    skid_dig_nxt   = skid_dig_r;
    if (pop) begin
      if (skid_valid_r) begin
        out_freq_nxt   = skid_freq_r;
        out_dig_nxt    = skid_dig_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt  = 1'b0;
      end
    end
    if (fire) begin
      if (!out_valid_nxt) begin
        out_freq_nxt   = flags_nxt;
        out_dig_nxt    = levels_nxt;
        out_valid_nxt  = 1'b1;
      end else begin
        skid_freq_nxt  = flags_nxt;
        skid_dig_nxt   = levels_nxt;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_freq_r  <= out_freq_nxt;
    out_dig_r   <= out_dig_nxt;
    skid_freq_r <= skid_freq_nxt;
    skid_dig_r  <= skid_dig_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_freq_detected  = out_freq_r;
  assign out_digital_inputs = out_dig_r;

endmodule

### src/fcwd_lane.sv
// One channel of the detector: edge time, edge period and detect flag.
module fcwd_lane (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic                        edge_in,
  input  logic                        freq_mode,
  input  logic [fcwd_pkg::TIME_W-1:0] now,
  input  fcwd_pkg::cfg_t              cfg,
  output logic                        flag_nxt
);

  logic [fcwd_pkg::TIME_W-1:0] last_edge_r, last_edge_nxt;
  logic [fcwd_pkg::TIME_W-1:0] period_r, period_nxt;
  logic [fcwd_pkg::TIME_W-1:0] age;
  logic                        flag_r;
  logic                        hit, recent, in_window;

  always_comb begin
    hit           = edge_in & freq_mode;
    last_edge_nxt = hit ? now : last_edge_r;
    period_nxt    = hit ? (now - last_edge_r) : period_r;
    age           = now - last_edge_nxt;
    recent        = age < {{(fcwd_pkg::TIME_W-fcwd_pkg::CFG_W){1'b0}}, cfg.edge_timeout};
    in_window     = (period_nxt > {{(fcwd_pkg::TIME_W-fcwd_pkg::CFG_W){1'b0}}, cfg.period_min})
                 && (period_nxt < {{(fcwd_pkg::TIME_W-fcwd_pkg::CFG_W){1'b0}}, cfg.period_max});
    // Hold the flag on a recent edge outside the window, drop it on timeout.
    flag_nxt      = recent & (flag_r | in_window);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_edge_r <= '0;
      period_r    <= '0;
      flag_r      <= 1'b0;
    end else if (fire) begin
      last_edge_r <= last_edge_nxt;
      period_r    <= period_nxt;
      flag_r      <= flag_nxt;
    end
  end

endmodule

### src/fcwd_sampler.sv
// Periodic sampler of the digital-mode pin levels.
module fcwd_sampler #(
  parameter int CHANNELS = fcwd_pkg::CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [fcwd_pkg::TIME_W-1:0] now,
  input  logic [CHANNELS-1:0]         pins,
  input  logic [CHANNELS-1:0]         freq_mode,
  input  fcwd_pkg::cfg_t              cfg,
  output logic [CHANNELS-1:0]         levels_nxt
);

  logic [fcwd_pkg::TIME_W-1:0] last_sample_r, last_sample_nxt;
  logic [CHANNELS-1:0]         sampled_r, sampled_nxt;
  logic                        take;

  always_comb begin
    take = (now - last_sample_r)
         > {{(fcwd_pkg::TIME_W-fcwd_pkg::CFG_W){1'b0}}, cfg.sample_period};
    last_sample_nxt = take ? now : last_sample_r;
    sampled_nxt     = take ? (pins & ~freq_mode) : sampled_r;
    levels_nxt      = sampled_nxt & ~freq_mode;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sample_r <= '0;
      sampled_r     <= '0;
    end else if (fire) begin
      last_sample_r <= last_sample_nxt;
      sampled_r     <= sampled_nxt;
    end
  end

endmodule
